// ----- src/dvr_pkg.sv -----
// shared types, codes and helpers for the distance-vector route update block
package dvr_pkg;

  localparam int COST_W    = 10;
  localparam int MAX_NODES = 4;

  typedef logic [COST_W-1:0]    cost_t;
  typedef logic [1:0]           node_t;
  typedef logic [MAX_NODES-1:0] node_mask_t;

  localparam cost_t INF_COST = 10'd999;

  // input word modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ADV  = 2'd1;
  localparam logic [1:0] MODE_UPD  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SELF  = 3'd0;
  localparam logic [2:0] REG_MASK  = 3'd1;
  localparam logic [2:0] REG_LINK0 = 3'd2;
  localparam logic [2:0] REG_LINK1 = 3'd3;
  localparam logic [2:0] REG_LINK2 = 3'd4;
  localparam logic [2:0] REG_LINK3 = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIN,
    ST_SEND
  } state_t;

  // per-row status handed from a lane to the merge stage
  typedef struct packed {
    cost_t min_cost;
    logic  changed;
  } lane_stat_t;

  function automatic cost_t sat_cost(input logic [COST_W:0] v);
    cost_t r;
    r = (v > {1'b0, INF_COST}) ? INF_COST : v[COST_W-1:0];
    return r;
  endfunction

endpackage

// ----- src/dvr_if.sv -----
// handshake channel interfaces: input word, routing packet, configuration write
interface dvr_in_if;
  import dvr_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  node_t       peer;
  node_t       dest;
  cost_t       load_cost;
  cost_t       adv_cost_0;
  cost_t       adv_cost_1;
  cost_t       adv_cost_2;
  cost_t       adv_cost_3;

  modport source (output valid, mode, peer, dest, load_cost,
                  adv_cost_0, adv_cost_1, adv_cost_2, adv_cost_3, input ready);
  modport sink   (input valid, mode, peer, dest, load_cost,
                  adv_cost_0, adv_cost_1, adv_cost_2, adv_cost_3, output ready);
endinterface

interface dvr_out_if;
  import dvr_pkg::*;
  logic  valid;
  logic  ready;
  node_t target_node;
  cost_t min_cost_0;
  cost_t min_cost_1;
  cost_t min_cost_2;
  cost_t min_cost_3;
  logic  last_packet;

  modport source (output valid, target_node, min_cost_0, min_cost_1, min_cost_2,
                  min_cost_3, last_packet, input ready);
  modport sink   (input valid, target_node, min_cost_0, min_cost_1, min_cost_2,
                  min_cost_3, last_packet, output ready);
endinterface

interface dvr_cfg_if;
  import dvr_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  cost_t       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/dvr_lane.sv -----
// one destination row of the distance table: load, relax and row minimum
module dvr_lane import dvr_pkg::*; #(
  parameter int NODES = 4,
  parameter int ROW   = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] mode,
  input  node_t      peer,
  input  node_t      dest,
  input  cost_t      load_cost,
  input  cost_t      adv_cost,
  input  cost_t      link_cost,
  output lane_stat_t stat
);

  cost_t row_r [MAX_NODES];
  logic  changed_r;
  cost_t new_cost;
  logic  lower;
  cost_t row_min;

  always_comb begin
    new_cost = sat_cost({1'b0, link_cost} + {1'b0, sat_cost({1'b0, adv_cost})});
    lower    = new_cost < row_r[peer];
  end

  // columns above NODES are kept so the change flag matches for small NODES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_NODES; c++) row_r[c] <= INF_COST;
      changed_r <= 1'b0;
    end else if (accept) begin
      changed_r <= 1'b0;
      case (mode)
        MODE_LOAD: begin
          if ((dest == node_t'(ROW)) && (int'(peer) < NODES))
            row_r[peer] <= sat_cost({1'b0, load_cost});
        end
        MODE_UPD: begin
          if (lower) begin
            row_r[peer] <= new_cost;
            changed_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    row_min = row_r[0];
    for (int c = 1; c < NODES; c++)
      if (row_r[c] < row_min) row_min = row_r[c];
    stat.min_cost = row_min;
    stat.changed  = changed_r;
  end

endmodule

// ----- src/dvr_merge.sv -----
// merges lane minimums and walks the neighbor list, one packet per live neighbor
module dvr_merge import dvr_pkg::*; #(
  parameter int NODES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       start_upd,
  input  lane_stat_t stat [MAX_NODES],
  input  node_t      self_node,
  input  node_mask_t neighbor_mask,
  output logic       idle,
  output logic       out_valid,
  input  logic       out_ready,
  output node_t      target,
  output cost_t      best [MAX_NODES],
  output logic       last
);

  state_t     state_r, state_nxt;
  logic       upd_r;
  node_mask_t pending_r, pending_nxt;
  cost_t      best_r [MAX_NODES];
  node_mask_t live;
  node_mask_t sel;
  logic       any_changed;

  always_comb begin
    any_changed = 1'b0;
    for (int n = 0; n < MAX_NODES; n++) begin
      live[n] = (n < NODES) && neighbor_mask[n] && (node_t'(n) != self_node);
      any_changed = any_changed | stat[n].changed;
    end
    // lowest pending neighbor goes first
    target = '0;
    sel    = '0;
    for (int n = MAX_NODES - 1; n >= 0; n--) begin
      if (pending_r[n]) begin
        target = node_t'(n);
        sel    = node_mask_t'(1) << n;
      end
    end
    last = (pending_r & (pending_r - node_mask_t'(1))) == '0;
  end

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    idle        = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) state_nxt = ST_MIN;
      end
      ST_MIN: begin
        pending_nxt = live;
        if ((!upd_r || any_changed) && (live != '0)) state_nxt = ST_SEND;
        else                                       state_nxt = ST_IDLE;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pending_nxt = pending_r & ~sel;
          if (last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= '0;
      upd_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      if (start) upd_r <= start_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MIN)
      for (int n = 0; n < MAX_NODES; n++) best_r[n] <= stat[n].min_cost;
  end

  always_comb begin
    for (int n = 0; n < MAX_NODES; n++) best[n] = best_r[n];
  end

endmodule

// ----- src/distance_vector_route_update_top.sv -----
// top level of the distance-vector route update block
//
//   channel   dir   handshake        word
//   in_ch     in    valid / ready    mode, peer, dest, load_cost, adv_cost_0..3
//   out_ch    out   valid / ready    target_node, min_cost_0..3, last_packet
//   cfg_ch    in    valid / ready    index, data
//
// load and unused mode words are accepted without starting the merge stage; advertise and
// update words pass the lanes, then the merge stage's minimum state, then one packet per
// cycle (up to three) while out_ch is ready, set by the single packet sequencer
// reset clears the table to 999 and the registers to their reset values at once
// a stalled out_ch holds the sequencer and keeps in_ch.ready low
module distance_vector_route_update_top import dvr_pkg::*; #(
  parameter int NODES = 4
) (
  input logic      clk,
  input logic      rst_n,
  dvr_in_if.sink   in_ch,
  dvr_out_if.source out_ch,
  dvr_cfg_if.sink  cfg_ch
);

  node_t      self_r;
  node_mask_t mask_r;
  cost_t      link_r [MAX_NODES];
  cost_t      adv [MAX_NODES];
  lane_stat_t stat [MAX_NODES];
  cost_t      best [MAX_NODES];
  logic       accept;
  logic       idle;
  logic       start;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r <= '0;
      mask_r <= '0;
      for (int n = 0; n < MAX_NODES; n++) link_r[n] <= INF_COST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SELF:  self_r    <= cfg_ch.data[1:0];
        REG_MASK:  mask_r    <= cfg_ch.data[MAX_NODES-1:0];
        REG_LINK0: link_r[0] <= sat_cost({1'b0, cfg_ch.data});
        REG_LINK1: link_r[1] <= sat_cost({1'b0, cfg_ch.data});
        REG_LINK2: link_r[2] <= sat_cost({1'b0, cfg_ch.data});
        REG_LINK3: link_r[3] <= sat_cost({1'b0, cfg_ch.data});
        default: ;
      endcase
    end
  end

  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept && ((in_ch.mode == MODE_ADV) || (in_ch.mode == MODE_UPD));

  assign adv[0] = in_ch.adv_cost_0;
  assign adv[1] = in_ch.adv_cost_1;
  assign adv[2] = in_ch.adv_cost_2;
  assign adv[3] = in_ch.adv_cost_3;

  for (genvar d = 0; d < MAX_NODES; d++) begin : g_row
    if (d < NODES) begin : g_lane
      dvr_lane #(.NODES(NODES), .ROW(d)) u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (in_ch.mode),
        .peer      (in_ch.peer),
        .dest      (in_ch.dest),
        .load_cost (in_ch.load_cost),
        .adv_cost  (adv[d]),
        .link_cost (link_r[in_ch.peer]),
        .stat      (stat[d])
      );
    end else begin : g_none
      // rows past the node count are never written
      assign stat[d] = '{min_cost: INF_COST, changed: 1'b0};
    end
  end

  dvr_merge #(.NODES(NODES)) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .start_upd     (in_ch.mode == MODE_UPD),
    .stat          (stat),
    .self_node     (self_r),
    .neighbor_mask (mask_r),
    .idle          (idle),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .target        (out_ch.target_node),
    .best          (best),
    .last          (out_ch.last_packet)
  );

  assign out_ch.min_cost_0 = best[0];
  assign out_ch.min_cost_1 = best[1];
  assign out_ch.min_cost_2 = best[2];
  assign out_ch.min_cost_3 = best[3];

`ifndef NO_ASSERTIONS
  a_no_accept_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a packet is pending");

  a_never_to_self: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.target_node != self_r))
    else $error("packet addressed to own node");

  a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("input ready during minimum merge");

  a_target_is_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> mask_r[out_ch.target_node])
    else $error("packet addressed to non-neighbor");
`endif

endmodule

// ----- verif/distance_vector_route_update_top_tb.sv -----
// testbench for the distance-vector route update block against a predictor
`timescale 1ns / 100ps

module distance_vector_route_update_top_tb;
  import dvr_pkg::*;

  localparam int NODES = 4;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_WORDS = 85;

  typedef struct packed {
    logic [1:0]  mode;
    node_t       peer;
    node_t       dest;
    cost_t       load_cost;
    cost_t [3:0] adv;
  } route_word_t;

  typedef struct packed {
    node_t       target_node;
    cost_t [3:0] min_cost;
    logic        last_packet;
  } route_pkt_t;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  dvr_in_if  in_bus ();
  dvr_out_if out_bus ();
  dvr_cfg_if cfg_bus ();

  distance_vector_route_update_top #(.NODES(NODES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // predictor state
  cost_t      route_tbl [NODES][NODES];
  node_t      self_id;
  node_mask_t nbr_mask;
  cost_t      link_cost_tbl [4];
  route_pkt_t expected_packets [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int packets_seen = 0;
  int mismatches = 0;

  route_pkt_t got_pkt;
  route_pkt_t want_pkt;

  function automatic cost_t clip_cost(input int unsigned v);
    return (v > INF_COST) ? INF_COST : cost_t'(v);
  endfunction

  function automatic void reset_route_model();
    foreach (route_tbl[d, v]) route_tbl[d][v] = INF_COST;
    self_id = '0;
    nbr_mask = '0;
    foreach (link_cost_tbl[n]) link_cost_tbl[n] = INF_COST;
  endfunction

  function automatic void apply_reg_write(input logic [2:0] idx, input cost_t value);
    case (idx)
      REG_SELF:  self_id = value[1:0];
      REG_MASK:  nbr_mask = value[3:0];
      REG_LINK0: link_cost_tbl[0] = clip_cost(value);
      REG_LINK1: link_cost_tbl[1] = clip_cost(value);
      REG_LINK2: link_cost_tbl[2] = clip_cost(value);
      REG_LINK3: link_cost_tbl[3] = clip_cost(value);
      default: ;
    endcase
  endfunction

  // per-destination minimum over next hops, one packet per neighbor other than self
  function automatic void queue_min_vector();
    cost_t      best [4];
    node_t      targets [$];
    route_pkt_t pkt;
    for (int d = 0; d < 4; d++) begin
      best[d] = (d < NODES) ? route_tbl[d][0] : INF_COST;
      for (int v = 1; v < NODES; v++)
        if (d < NODES && route_tbl[d][v] < best[d]) best[d] = route_tbl[d][v];
    end
    for (int n = 0; n < NODES; n++)
      if (nbr_mask[n] && n != int'(self_id)) targets.push_back(node_t'(n));
    foreach (targets[i]) begin
      pkt.target_node = targets[i];
      for (int d = 0; d < 4; d++) pkt.min_cost[d] = best[d];
      pkt.last_packet = (i == targets.size() - 1);
      expected_packets.push_back(pkt);
    end
  endfunction

  function automatic void apply_route_word(input route_word_t w);
    logic        changed;
    cost_t       new_cost;
    int unsigned sum;
    case (w.mode)
      MODE_LOAD: begin
        if (w.peer < NODES && w.dest < NODES)
          route_tbl[w.dest][w.peer] = clip_cost(w.load_cost);
      end
      MODE_ADV: queue_min_vector();
      MODE_UPD: begin
        changed = 1'b0;
        for (int d = 0; d < NODES; d++) begin
          sum = int'(link_cost_tbl[w.peer]) + int'(clip_cost(w.adv[d]));
          new_cost = clip_cost(sum);
          if (new_cost < route_tbl[d][w.peer]) begin
            route_tbl[d][w.peer] = new_cost;
            changed = 1'b1;
          end
        end
        if (changed) queue_min_vector();
      end
      default: ;
    endcase
  endfunction

  function automatic void report_packet(input string what, input bit have_want,
                                        input route_pkt_t want, input route_pkt_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (have_want) begin
        $write("%0t %s: expected to=%0d min=%0d/%0d/%0d/%0d last=%0b, ",
               $time, what, want.target_node, want.min_cost[0], want.min_cost[1],
               want.min_cost[2], want.min_cost[3], want.last_packet);
        $display("got to=%0d min=%0d/%0d/%0d/%0d last=%0b", got.target_node,
                 got.min_cost[0], got.min_cost[1], got.min_cost[2], got.min_cost[3],
                 got.last_packet);
      end else begin
        $display("%0t %s: got to=%0d min=%0d/%0d/%0d/%0d last=%0b", $time, what,
                 got.target_node, got.min_cost[0], got.min_cost[1], got.min_cost[2],
                 got.min_cost[3], got.last_packet);
      end
    end
  endfunction

  // packet checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      packets_seen++;
      got_pkt.target_node = out_bus.target_node;
      got_pkt.min_cost[0] = out_bus.min_cost_0;
      got_pkt.min_cost[1] = out_bus.min_cost_1;
      got_pkt.min_cost[2] = out_bus.min_cost_2;
      got_pkt.min_cost[3] = out_bus.min_cost_3;
      got_pkt.last_packet = out_bus.last_packet;
      if (expected_packets.size() == 0) begin
        report_packet("unexpected packet", 1'b0, got_pkt, got_pkt);
      end else begin
        want_pkt = expected_packets.pop_front();
        if (got_pkt.target_node !== want_pkt.target_node ||
            got_pkt.min_cost[0] !== want_pkt.min_cost[0] ||
            got_pkt.min_cost[1] !== want_pkt.min_cost[1] ||
            got_pkt.min_cost[2] !== want_pkt.min_cost[2] ||
            got_pkt.min_cost[3] !== want_pkt.min_cost[3] ||
            got_pkt.last_packet !== want_pkt.last_packet)
          report_packet("packet mismatch", 1'b1, want_pkt, got_pkt);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic route_word_t make_word(input logic [1:0] mode, input node_t peer,
                                            input node_t dest, input cost_t load_cost,
                                            input cost_t a0, input cost_t a1,
                                            input cost_t a2, input cost_t a3);
    route_word_t w;
    w.mode = mode;
    w.peer = peer;
    w.dest = dest;
    w.load_cost = load_cost;
    w.adv[0] = a0;
    w.adv[1] = a1;
    w.adv[2] = a2;
    w.adv[3] = a3;
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input route_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= w.mode;
    in_bus.peer       <= w.peer;
    in_bus.dest       <= w.dest;
    in_bus.load_cost  <= w.load_cost;
    in_bus.adv_cost_0 <= w.adv[0];
    in_bus.adv_cost_1 <= w.adv[1];
    in_bus.adv_cost_2 <= w.adv[2];
    in_bus.adv_cost_3 <= w.adv[3];
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    apply_route_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input cost_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    apply_reg_write(idx, value);
    @(negedge clk);
  endtask

  task automatic write_all_regs(input cost_t self_v, input cost_t mask_v, input cost_t l0,
                                input cost_t l1, input cost_t l2, input cost_t l3);
    write_reg(REG_SELF, self_v);
    write_reg(REG_MASK, mask_v);
    write_reg(REG_LINK0, l0);
    write_reg(REG_LINK1, l1);
    write_reg(REG_LINK2, l2);
    write_reg(REG_LINK3, l3);
    cfg_bus.valid <= 1'b0;
  endtask

  // sender holds off until every predicted packet is out, then the block settles
  task automatic wait_for_quiet();
    int waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    while (expected_packets.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic cost_t rand_cost();
    case ($urandom_range(7))
      0:       return '0;
      1:       return INF_COST;
      2:       return cost_t'($urandom_range(1000, 1023));
      3, 4:    return cost_t'($urandom_range(0, 999));
      default: return cost_t'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic test_reset_state();
    // no neighbors and every link at infinity
    send_word(make_word(MODE_ADV, 2'd0, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_UPD, 2'd0, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_UPD, 2'd3, 2'd3, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                        10'd1023));
    wait_for_quiet();
    // table changes but nobody to tell
    write_reg(REG_LINK0, 10'd0);
    cfg_bus.valid <= 1'b0;
    send_word(make_word(MODE_UPD, 2'd0, 2'd0, 10'd0, 10'd7, 10'd999, 10'd3, 10'd1000));
    wait_for_quiet();
  endtask

  task automatic test_register_writes();
    // upper data bits ignored, link above 999 saturates, spare index ignored
    write_reg(REG_SELF, 10'h3fd);
    write_reg(REG_MASK, 10'h3ff);
    write_reg(REG_LINK0, 10'd5);
    write_reg(REG_LINK1, 10'd0);
    write_reg(REG_LINK2, 10'd999);
    write_reg(REG_LINK3, 10'd1023);
    write_reg(REG_SPARE, 10'h155);
    cfg_bus.valid <= 1'b0;
    // self bit set in the mask: three packets, none to self
    send_word(make_word(MODE_ADV, 2'd1, 2'd2, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    wait_for_quiet();
  endtask

  task automatic test_load_and_advertise();
    send_word(make_word(MODE_LOAD, 2'd0, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_LOAD, 2'd3, 2'd3, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_LOAD, 2'd1, 2'd2, 10'd998, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_LOAD, 2'd2, 2'd1, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(MODE_LOAD, 2'd3, 2'd1, 10'd512, 10'd0, 10'd0, 10'd0, 10'd0));
    // unused mode with every bit high is dropped
    send_word(make_word(MODE_UNUSED, 2'd3, 2'd3, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                        10'd1023));
    send_word(make_word(MODE_ADV, 2'd0, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    wait_for_quiet();
  endtask

  task automatic test_update_rules();
    send_word(make_word(MODE_UPD, 2'd1, 2'd0, 10'd0, 10'd0, 10'd1023, 10'd500, 10'd999));
    // same vector again lowers nothing
    send_word(make_word(MODE_UPD, 2'd1, 2'd0, 10'd0, 10'd0, 10'd1023, 10'd500, 10'd999));
    // link at infinity
    send_word(make_word(MODE_UPD, 2'd2, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    // update from self is handled like any other
    send_word(make_word(MODE_UPD, 2'd1, 2'd0, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1));
    send_word(make_word(MODE_UPD, 2'd3, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    // sum saturates at 999, just below it lowers
    send_word(make_word(MODE_UPD, 2'd0, 2'd0, 10'd0, 10'd994, 10'd994, 10'd994, 10'd994));
    send_word(make_word(MODE_UPD, 2'd0, 2'd0, 10'd0, 10'd993, 10'd993, 10'd993, 10'd993));
    send_word(make_word(MODE_ADV, 2'd0, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    wait_for_quiet();
  endtask

  task automatic run_phase(input int idle, input int stall, input cost_t self_v,
                           input cost_t mask_v, input cost_t l0, input cost_t l1,
                           input cost_t l2, input cost_t l3);
    int          counted;
    int          sel;
    route_word_t w;
    wait_for_quiet();
    send_idle_pct = idle;
    stall_pct = stall;
    write_all_regs(self_v, mask_v, l0, l1, l2, l3);
    counted = 0;
    while (counted < PHASE_WORDS) begin
      sel = $urandom_range(99);
      w = make_word(MODE_UNUSED, node_t'($urandom_range(3)), node_t'($urandom_range(3)),
                    cost_t'($urandom_range(1023)), rand_cost(), rand_cost(), rand_cost(),
                    rand_cost());
      if (sel < 30) begin
        w.mode = MODE_LOAD;
        // mostly high loads so later updates keep finding room to lower
        if ($urandom_range(3) != 0) w.load_cost = cost_t'($urandom_range(400, 1023));
      end else if (sel < 50) begin
        w.mode = MODE_ADV;
      end else if (sel < 95) begin
        w.mode = MODE_UPD;
      end
      send_word(w);
      if (w.mode != MODE_UNUSED) counted++;
      if (counted == PHASE_WORDS / 2 && w.mode != MODE_UNUSED) wait_for_quiet();
    end
    wait_for_quiet();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 10'd0, 10'b1110, 10'd0, 10'd3, 10'd17, 10'd250);
    run_phase(81, 0, 10'd2, 10'b1111, 10'd1023, 10'd999, 10'd0, 10'd40);
    run_phase(0, 81, 10'd1, 10'b1011, cost_t'($urandom_range(1023)),
              cost_t'($urandom_range(300)), cost_t'($urandom_range(300)),
              cost_t'($urandom_range(1023)));
    run_phase(35, 35, 10'd3, 10'b0111, cost_t'($urandom_range(100)),
              cost_t'($urandom_range(100)), cost_t'($urandom_range(999)), 10'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_LOAD;
    in_bus.peer = '0;
    in_bus.dest = '0;
    in_bus.load_cost = '0;
    in_bus.adv_cost_0 = '0;
    in_bus.adv_cost_1 = '0;
    in_bus.adv_cost_2 = '0;
    in_bus.adv_cost_3 = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_SELF;
    cfg_bus.data = '0;
    out_bus.ready = 1'b1;
    reset_route_model();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_register_writes();
    test_load_and_advertise();
    test_update_rules();
    test_random_traffic();

    wait_for_quiet();
    if (expected_packets.size() != 0) begin
      $display("%0d predicted packets never arrived", expected_packets.size());
      mismatches += expected_packets.size();
    end
    $display("covered %0d input words under four sender/receiver throttle mixes", words_sent);
    $display("checked %0d routing packets, %0d mismatches", packets_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting on the block");
    $display("status: fail");
    $finish;
  end

endmodule
